>>> rtl/tsbf_pkg.sv
package tsbf_pkg;

    // block constants
    localparam int AVG_COUNT = 5;
    localparam int ADC_BITS  = 12;
    localparam int FRAC_BITS = 8;

    // fixed field widths
    localparam int MS_W         = 32;
    localparam int REFRESH_W    = 16;
    localparam int SENSOR_S_W   = 8;
    localparam int SENSOR_CNT_W = 18;
    localparam int SAMPLE_W     = 16;
    localparam int GAIN_W       = 9;
    localparam int THRESH_W     = 20;
    localparam int SCALE_W      = 18;
    localparam int OFFSET_W     = 12;
    localparam int MV_W         = 14;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;

    localparam int GAIN_FRAC   = 8;
    localparam int GAIN_ONE    = 256;
    localparam int TICKS_PER_S = 1000;
    localparam int MV_MIN      = -2048;
    localparam int MV_MAX      = 8191;
    localparam int MV_CLAMP    = MV_MAX + 4096;

    // derived widths
    localparam int IDX_W    = $clog2(AVG_COUNT + 1);
    localparam int SUM_W    = $clog2(AVG_COUNT * ((1 << ADC_BITS) - 1) + 1);
    localparam int NUM_W    = SUM_W + FRAC_BITS;
    localparam int AVG_W    = ADC_BITS + FRAC_BITS;
    localparam int PROD_W   = AVG_W + SCALE_W;
    localparam int ACC_W    = AVG_W + GAIN_W + 1;
    localparam int MV_SHIFT = FRAC_BITS + 16;
    localparam int R_W      = PROD_W + 1 - MV_SHIFT;
    localparam int CMP_W    = (AVG_W > THRESH_W) ? AVG_W : THRESH_W;

    // reciprocal of the sample count, exact for every numerator below 2^NUM_W
    localparam int     RECIP_SHIFT = NUM_W + $clog2(AVG_COUNT);
    localparam longint RECIP_MUL   = ((longint'(1) << RECIP_SHIFT) + longint'(AVG_COUNT) - 1)
                                     / longint'(AVG_COUNT);
    localparam int     DIVP_W      = RECIP_SHIFT + NUM_W;

    // register reset values
    localparam int RST_REFRESH_PERIOD  = 200;
    localparam int RST_SENSOR_PERIOD_S = 5;
    localparam int RST_SAMPLE_PERIOD   = 2000;
    localparam int RST_NORMAL_GAIN     = 77;
    localparam int RST_JUMP_GAIN       = 154;
    localparam int RST_JUMP_THRESHOLD  = 15888;
    localparam int RST_CALIB_SCALE     = 110880;
    localparam int RST_CALIB_OFFSET_MV = -120;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REFRESH_PERIOD,
        CFG_SENSOR_PERIOD_S,
        CFG_SAMPLE_PERIOD,
        CFG_NORMAL_GAIN,
        CFG_JUMP_GAIN,
        CFG_JUMP_THRESHOLD,
        CFG_CALIB_SCALE,
        CFG_CALIB_OFFSET_MV
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV,
        ST_FILT_A,
        ST_FILT_B,
        ST_FILT_C,
        ST_LOAD,
        ST_MV_A,
        ST_MV_B,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic tick;
        logic div_step;
        logic mul_gain;
        logic mul_rest;
        logic filt_update;
        logic filt_load;
        logic mul_scale;
        logic mv_update;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic avg_due;
        logic primed;
    } st_t;

endpackage

>>> rtl/tsbf_ctrl.sv
module tsbf_ctrl
    import tsbf_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    output logic m_valid,
    input  logic m_ready,
    input  st_t  st,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = st.avg_due ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:    state_next = st.primed ? ST_FILT_A : ST_LOAD;
            ST_FILT_A: state_next = ST_FILT_B;
            ST_FILT_B: state_next = ST_FILT_C;
            ST_FILT_C: state_next = ST_MV_A;
            ST_LOAD:   state_next = ST_MV_A;
            ST_MV_A:   state_next = ST_MV_B;
            ST_MV_B:   state_next = ST_OUT;
            ST_OUT: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        case (state_reg)
            ST_IDLE:   cmd.tick        = s_valid;
            ST_DIV:    cmd.div_step    = 1'b1;
            ST_FILT_A: cmd.mul_gain    = 1'b1;
            ST_FILT_B: cmd.mul_rest    = 1'b1;
            ST_FILT_C: cmd.filt_update = 1'b1;
            ST_LOAD:   cmd.filt_load   = 1'b1;
            ST_MV_A:   cmd.mul_scale   = 1'b1;
            ST_MV_B:   cmd.mv_update   = 1'b1;
            ST_OUT:    cmd.out_load    = out_free;
            default:   cmd = '0;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

>>> rtl/tsbf_dp.sv
module tsbf_dp
    import tsbf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic [ADC_BITS-1:0]   s_adc_code,
    input  cmd_t                  cmd,
    output st_t                   st,
    output logic [MS_W-1:0]       m_elapsed_ms,
    output logic                  m_refresh_pulse,
    output logic                  m_sensor_pulse,
    output logic                  m_voltage_update,
    output logic signed [MV_W-1:0] m_battery_mv
);

    // configuration registers
    logic [REFRESH_W-1:0]         refresh_period_reg;
    logic [SENSOR_S_W-1:0]        sensor_period_s_reg;
    logic [SAMPLE_W-1:0]          sample_period_reg;
    logic [GAIN_W-1:0]            normal_gain_reg;
    logic [GAIN_W-1:0]            jump_gain_reg;
    logic [THRESH_W-1:0]          jump_threshold_reg;
    logic [SCALE_W-1:0]           calib_scale_reg;
    logic signed [OFFSET_W-1:0]   calib_offset_reg;

    // tick state
    logic [MS_W-1:0]         ms_reg;
    logic [REFRESH_W-1:0]    refresh_cnt_reg;
    logic [SENSOR_CNT_W-1:0] sensor_cnt_reg;
    logic [SAMPLE_W-1:0]     sample_cnt_reg;
    logic [IDX_W-1:0]        avg_idx_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic                    refresh_hit_reg, sensor_hit_reg, update_reg;

    // divider, filter and scaling
    logic [NUM_W-1:0]        q_reg;
    logic [AVG_W-1:0]        filt_reg, prev_reg;
    logic                    primed_reg;
    logic [GAIN_W-1:0]       gain_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [ACC_W-1:0]        acc_reg;
    logic signed [MV_W-1:0]  mv_reg, mv_next;

    // counter next values
    logic [MS_W-1:0]           ms_next;
    logic [REFRESH_W:0]        refresh_inc;
    logic [SENSOR_CNT_W:0]     sensor_inc;
    logic [SAMPLE_W:0]         sample_inc;
    logic [SENSOR_CNT_W-1:0]   sensor_period;
    logic                      refresh_fire, sensor_fire, sample_fire, avg_due;
    logic [IDX_W-1:0]          idx_inc;
    logic [SUM_W-1:0]          sum_add;

    // division by the sample count
    logic [DIVP_W-1:0]         div_prod;

    // filter math
    logic [AVG_W-1:0]          avg;
    logic [AVG_W-1:0]          diff;
    logic [GAIN_W-1:0]         gain_raw, gain_sat;
    logic [AVG_W-1:0]          mul_a;
    logic [SCALE_W-1:0]        mul_b;
    logic [ACC_W-1:0]          filt_sum;

    // millivolt math
    logic [PROD_W:0]           mv_round;
    logic [R_W-1:0]            mv_r;
    logic [MV_W-1:0]           mv_clamp;
    logic signed [MV_W+1:0]    mv_sum;

    assign ms_next       = ms_reg + MS_W'(1);
    assign refresh_inc   = {1'b0, refresh_cnt_reg} + (REFRESH_W+1)'(1);
    assign sensor_period = SENSOR_CNT_W'(sensor_period_s_reg) * SENSOR_CNT_W'(TICKS_PER_S);
    assign sensor_inc    = {1'b0, sensor_cnt_reg} + (SENSOR_CNT_W+1)'(1);
    assign sample_inc    = {1'b0, sample_cnt_reg} + (SAMPLE_W+1)'(1);
    assign refresh_fire  = refresh_inc >= {1'b0, refresh_period_reg};
    assign sensor_fire   = sensor_inc >= {1'b0, sensor_period};
    assign sample_fire   = sample_inc >= {1'b0, sample_period_reg};
    assign idx_inc       = avg_idx_reg + IDX_W'(1);
    assign avg_due       = sample_fire && (idx_inc >= IDX_W'(AVG_COUNT));
    assign sum_add       = sum_reg + SUM_W'(s_adc_code);

    // quotient by the constant count through its reciprocal
    assign div_prod = DIVP_W'(q_reg) * DIVP_W'(RECIP_MUL);

    assign avg      = q_reg[AVG_W-1:0];
    assign diff     = (avg > prev_reg) ? (avg - prev_reg) : (prev_reg - avg);
    assign gain_raw = (CMP_W'(diff) > CMP_W'(jump_threshold_reg)) ? jump_gain_reg
                                                                  : normal_gain_reg;
    assign gain_sat = (gain_raw > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain_raw;

    // one shared multiplier, registered
    always_comb begin
        mul_a = filt_reg;
        mul_b = calib_scale_reg;
        if (cmd.mul_gain) begin
            mul_a = avg;
            mul_b = SCALE_W'(gain_sat);
        end else if (cmd.mul_rest) begin
            mul_b = SCALE_W'(GAIN_W'(GAIN_ONE) - gain_reg);
        end
    end

    assign filt_sum = acc_reg + ACC_W'(prod_reg) + ACC_W'(GAIN_ONE / 2);

    assign mv_round = {1'b0, prod_reg} + ((PROD_W+1)'(1) << (MV_SHIFT - 1));
    assign mv_r     = mv_round[PROD_W:MV_SHIFT];
    assign mv_clamp = (mv_r > R_W'(MV_CLAMP)) ? MV_W'(MV_CLAMP) : mv_r[MV_W-1:0];
    assign mv_sum   = $signed({2'b00, mv_clamp}) + (MV_W+2)'(calib_offset_reg);

    always_comb begin
        if (mv_sum > (MV_W+2)'(MV_MAX)) begin
            mv_next = MV_W'(MV_MAX);
        end else if (mv_sum < (MV_W+2)'(MV_MIN)) begin
            mv_next = MV_W'(MV_MIN);
        end else begin
            mv_next = mv_sum[MV_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            refresh_period_reg  <= REFRESH_W'(RST_REFRESH_PERIOD);
            sensor_period_s_reg <= SENSOR_S_W'(RST_SENSOR_PERIOD_S);
            sample_period_reg   <= SAMPLE_W'(RST_SAMPLE_PERIOD);
            normal_gain_reg     <= GAIN_W'(RST_NORMAL_GAIN);
            jump_gain_reg       <= GAIN_W'(RST_JUMP_GAIN);
            jump_threshold_reg  <= THRESH_W'(RST_JUMP_THRESHOLD);
            calib_scale_reg     <= SCALE_W'(RST_CALIB_SCALE);
            calib_offset_reg    <= OFFSET_W'(RST_CALIB_OFFSET_MV);
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_index))
                CFG_REFRESH_PERIOD:  refresh_period_reg  <= cfg_wr_data[REFRESH_W-1:0];
                CFG_SENSOR_PERIOD_S: sensor_period_s_reg <= cfg_wr_data[SENSOR_S_W-1:0];
                CFG_SAMPLE_PERIOD:   sample_period_reg   <= cfg_wr_data[SAMPLE_W-1:0];
                CFG_NORMAL_GAIN:     normal_gain_reg     <= cfg_wr_data[GAIN_W-1:0];
                CFG_JUMP_GAIN:       jump_gain_reg       <= cfg_wr_data[GAIN_W-1:0];
                CFG_JUMP_THRESHOLD:  jump_threshold_reg  <= cfg_wr_data[THRESH_W-1:0];
                CFG_CALIB_SCALE:     calib_scale_reg     <= cfg_wr_data[SCALE_W-1:0];
                CFG_CALIB_OFFSET_MV: calib_offset_reg    <= $signed(cfg_wr_data[OFFSET_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ms_reg          <= '0;
            refresh_cnt_reg <= '0;
            sensor_cnt_reg  <= '0;
            sample_cnt_reg  <= '0;
            avg_idx_reg     <= '0;
            sum_reg         <= '0;
            filt_reg        <= '0;
            prev_reg        <= '0;
            primed_reg      <= 1'b0;
            mv_reg          <= '0;
        end else begin
            if (cmd.tick) begin
                ms_reg          <= ms_next;
                refresh_cnt_reg <= refresh_fire ? '0 : refresh_inc[REFRESH_W-1:0];
                sensor_cnt_reg  <= sensor_fire ? '0 : sensor_inc[SENSOR_CNT_W-1:0];
                sample_cnt_reg  <= sample_fire ? '0 : sample_inc[SAMPLE_W-1:0];
                if (sample_fire) begin
                    avg_idx_reg <= avg_due ? '0 : idx_inc;
                    sum_reg     <= avg_due ? '0 : sum_add;
                end
            end
            if (cmd.filt_update) begin
                filt_reg <= filt_sum[AVG_W+GAIN_FRAC-1:GAIN_FRAC];
                prev_reg <= avg;
            end
            if (cmd.filt_load) begin
                filt_reg   <= avg;
                prev_reg   <= avg;
                primed_reg <= 1'b1;
            end
            if (cmd.mv_update) begin
                mv_reg <= mv_next;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (cmd.tick) begin
            refresh_hit_reg <= refresh_fire;
            sensor_hit_reg  <= sensor_fire;
            update_reg      <= avg_due;
            q_reg           <= (NUM_W'(sum_add) << FRAC_BITS) + NUM_W'(AVG_COUNT / 2);
        end
        if (cmd.div_step) begin
            q_reg <= div_prod[RECIP_SHIFT +: NUM_W];
        end
        if (cmd.mul_gain) begin
            gain_reg <= gain_sat;
        end
        if (cmd.mul_rest) begin
            acc_reg <= ACC_W'(prod_reg);
        end
        prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.out_load) begin
            m_elapsed_ms     <= ms_reg;
            m_refresh_pulse  <= refresh_hit_reg;
            m_sensor_pulse   <= sensor_hit_reg;
            m_voltage_update <= update_reg;
            m_battery_mv     <= mv_reg;
        end
    end

    assign st.avg_due = avg_due;
    assign st.primed  = primed_reg;

endmodule

>>> rtl/tick_scheduler_battery_filter.sv
// Millisecond tick scheduler with a filtered battery monitor. Every accepted item is one
// tick; it returns one item with the elapsed count, refresh and sensor pulses, and the
// held battery voltage in millivolts. A tick that completes no average passes only the
// output state before the result register, and the block takes a new tick only back in
// idle. A tick that completes an average passes the divide, filter, scaling and output
// states in turn (the very first average loads the filter directly instead): the divide
// state forms the average by a reciprocal multiplication with the constant sample count,
// and the filter and the millivolt scaling then share one registered 20x18 multiplier.
// A result waits in the output register while the next item is already accepted;
// a stalled receiver holds that next item in the block once it is done.
module tick_scheduler_battery_filter
    import tsbf_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [ADC_BITS-1:0]    s_adc_code,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [MS_W-1:0]        m_elapsed_ms,
    output logic                   m_refresh_pulse,
    output logic                   m_sensor_pulse,
    output logic                   m_voltage_update,
    output logic signed [MV_W-1:0] m_battery_mv
);

    cmd_t cmd;
    st_t  st;

    tsbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    tsbf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_adc_code       (s_adc_code),
        .cmd              (cmd),
        .st               (st),
        .m_elapsed_ms     (m_elapsed_ms),
        .m_refresh_pulse  (m_refresh_pulse),
        .m_sensor_pulse   (m_sensor_pulse),
        .m_voltage_update (m_voltage_update),
        .m_battery_mv     (m_battery_mv)
    );

endmodule

>>> rtl/tsbf_chk.sv
module tsbf_chk
    import tsbf_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_valid,
    input logic                   s_ready,
    input logic [ADC_BITS-1:0]    s_adc_code,
    input logic                   m_valid,
    input logic                   m_ready,
    input logic [MS_W-1:0]        m_elapsed_ms,
    input logic                   m_refresh_pulse,
    input logic                   m_sensor_pulse,
    input logic                   m_voltage_update,
    input logic signed [MV_W-1:0] m_battery_mv
);

    // one item in work at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while an item is in work");

    // a waiting input item holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_adc_code))
        else $error("waiting input changed");

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_elapsed_ms) && $stable(m_battery_mv)
            && $stable(m_refresh_pulse) && $stable(m_sensor_pulse)
            && $stable(m_voltage_update))
        else $error("stalled result changed");

    // voltage stays at or above the lower saturation bound
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_battery_mv >= MV_W'(MV_MIN))
        else $error("battery voltage below range");

    // no result right after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown after reset");

endmodule

bind tick_scheduler_battery_filter tsbf_chk u_tsbf_chk (.*);

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsbf_pkg::*;

    localparam int CODE_MAX       = (1 << ADC_BITS) - 1;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int DRAIN_CYCLES   = 40;

    typedef struct {
        logic [MS_W-1:0]        elapsed_ms;
        logic                   refresh_pulse;
        logic                   sensor_pulse;
        logic                   voltage_update;
        logic signed [MV_W-1:0] battery_mv;
    } tick_result_t;

    class tick_result_tracker;
        bit [REFRESH_W-1:0]         refresh_period;
        bit [SENSOR_S_W-1:0]        sensor_period_s;
        bit [SAMPLE_W-1:0]          sample_period;
        bit [GAIN_W-1:0]            normal_gain;
        bit [GAIN_W-1:0]            jump_gain;
        bit [THRESH_W-1:0]          jump_threshold;
        bit [SCALE_W-1:0]           calib_scale;
        bit signed [OFFSET_W-1:0]   calib_offset_mv;

        bit [MS_W-1:0]              ms_count;
        bit [REFRESH_W-1:0]         refresh_cnt;
        bit [SENSOR_CNT_W-1:0]      sensor_cnt;
        bit [SAMPLE_W-1:0]          sample_cnt;
        bit [IDX_W-1:0]             avg_idx;
        bit [SUM_W-1:0]             sample_sum;
        bit [AVG_W-1:0]             filtered_code;
        bit [AVG_W-1:0]             prev_average;
        bit                         primed;
        bit signed [MV_W-1:0]       voltage_mv;

        tick_result_t owed_results[$];
        int mismatches, ticks, results, updates, jumps, refreshes, sensors;

        function new();
            refresh_period  = REFRESH_W'(RST_REFRESH_PERIOD);
            sensor_period_s = SENSOR_S_W'(RST_SENSOR_PERIOD_S);
            sample_period   = SAMPLE_W'(RST_SAMPLE_PERIOD);
            normal_gain     = GAIN_W'(RST_NORMAL_GAIN);
            jump_gain       = GAIN_W'(RST_JUMP_GAIN);
            jump_threshold  = THRESH_W'(RST_JUMP_THRESHOLD);
            calib_scale     = SCALE_W'(RST_CALIB_SCALE);
            calib_offset_mv = OFFSET_W'(RST_CALIB_OFFSET_MV);
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_REFRESH_PERIOD:  refresh_period  = d[REFRESH_W-1:0];
                CFG_SENSOR_PERIOD_S: sensor_period_s = d[SENSOR_S_W-1:0];
                CFG_SAMPLE_PERIOD:   sample_period   = d[SAMPLE_W-1:0];
                CFG_NORMAL_GAIN:     normal_gain     = d[GAIN_W-1:0];
                CFG_JUMP_GAIN:       jump_gain       = d[GAIN_W-1:0];
                CFG_JUMP_THRESHOLD:  jump_threshold  = d[THRESH_W-1:0];
                CFG_CALIB_SCALE:     calib_scale     = d[SCALE_W-1:0];
                CFG_CALIB_OFFSET_MV: calib_offset_mv = d[OFFSET_W-1:0];
                default: ;
            endcase
        endfunction

        // a counter at or past its period (zero included) fires and restarts
        function bit period_done(input bit [31:0] cnt, input bit [31:0] period,
                                 output bit [31:0] next_cnt);
            next_cnt = cnt + 1;
            if (next_cnt >= period) begin
                next_cnt = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void predict_tick(logic [ADC_BITS-1:0] code);
            tick_result_t r;
            bit [31:0]    c, num, acc, diff;
            bit [AVG_W-1:0] avg;
            bit [GAIN_W-1:0] g;
            bit [PROD_W:0] prod;
            bit           sample_due;
            bit           jump;
            int           mv;
            ticks++;
            ms_count++;
            r.voltage_update = 1'b0;
            r.refresh_pulse = period_done(32'(refresh_cnt), 32'(refresh_period), c);
            refresh_cnt = c[REFRESH_W-1:0];
            r.sensor_pulse = period_done(32'(sensor_cnt), 32'(sensor_period_s) * TICKS_PER_S,
                                         c);
            sensor_cnt = c[SENSOR_CNT_W-1:0];
            sample_due = period_done(32'(sample_cnt), 32'(sample_period), c);
            sample_cnt = c[SAMPLE_W-1:0];
            if (sample_due) begin
                sample_sum += code;
                avg_idx++;
                if (avg_idx >= AVG_COUNT) begin
                    num = 32'(sample_sum);
                    num = ((num << FRAC_BITS) + AVG_COUNT / 2) / AVG_COUNT;
                    avg = num[AVG_W-1:0];
                    if (!primed) begin
                        filtered_code = avg;
                        primed = 1'b1;
                    end else begin
                        diff = 32'((avg > prev_average) ? avg - prev_average
                                                        : prev_average - avg);
                        jump = diff > jump_threshold;
                        if (jump) jumps++;
                        g = jump ? jump_gain : normal_gain;
                        if (g > GAIN_ONE) g = GAIN_W'(GAIN_ONE);
                        acc = g * avg + (GAIN_ONE - g) * filtered_code + 128;
                        filtered_code = acc[AVG_W+7:8];
                    end
                    prev_average = avg;
                    // scale to millivolts, round, clamp, then add the offset
                    prod = filtered_code * calib_scale;
                    prod = (prod + (1 << (MV_SHIFT - 1))) >> MV_SHIFT;
                    if (prod > MV_CLAMP) prod = (PROD_W+1)'(MV_CLAMP);
                    mv = int'(prod[15:0]);
                    mv = mv + calib_offset_mv;
                    if (mv > MV_MAX) mv = MV_MAX;
                    if (mv < MV_MIN) mv = MV_MIN;
                    voltage_mv = mv[MV_W-1:0];
                    sample_sum = '0;
                    avg_idx = '0;
                    r.voltage_update = 1'b1;
                    updates++;
                end
            end
            if (r.refresh_pulse) refreshes++;
            if (r.sensor_pulse) sensors++;
            r.elapsed_ms = ms_count;
            r.battery_mv = voltage_mv;
            owed_results.push_back(r);
        endfunction

        task report(string field, longint got, longint want);
            mismatches++;
            $display("mismatch at result %0d, %s: got %0d, expected %0d",
                     results, field, got, want);
        endtask

        task check_result(logic [MS_W-1:0] elapsed, logic refresh, logic sensor,
                          logic update, logic signed [MV_W-1:0] mv);
            tick_result_t want;
            if (owed_results.size() == 0) begin
                report("item with nothing owed, elapsed_ms", elapsed, -1);
                return;
            end
            want = owed_results.pop_front();
            results++;
            if (elapsed !== want.elapsed_ms) report("elapsed_ms", elapsed, want.elapsed_ms);
            if (refresh !== want.refresh_pulse)
                report("refresh_pulse", refresh, want.refresh_pulse);
            if (sensor !== want.sensor_pulse)
                report("sensor_pulse", sensor, want.sensor_pulse);
            if (update !== want.voltage_update)
                report("voltage_update", update, want.voltage_update);
            if (mv !== want.battery_mv) report("battery_mv", mv, want.battery_mv);
        endtask
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    cfg_idx_t               cfg_index = CFG_REFRESH_PERIOD;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [ADC_BITS-1:0]    s_adc_code = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [MS_W-1:0]        m_elapsed_ms;
    logic                   m_refresh_pulse;
    logic                   m_sensor_pulse;
    logic                   m_voltage_update;
    logic signed [MV_W-1:0] m_battery_mv;

    tick_result_tracker tracker = new();

    int stall_pct = 0;
    int hold_requests = 0;
    int hold_served = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int settings_used = 0;
    int adc_level = 2048;

    tick_scheduler_battery_filter uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_adc_code       (s_adc_code),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_elapsed_ms     (m_elapsed_ms),
        .m_refresh_pulse  (m_refresh_pulse),
        .m_sensor_pulse   (m_sensor_pulse),
        .m_voltage_update (m_voltage_update),
        .m_battery_mv     (m_battery_mv)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // receiver: random stalls, plus a long hold-off when one is requested
    always @(negedge aclk) begin
        if (hold_requests != hold_served) begin
            hold_left = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_wr_en) tracker.write_reg(cfg_index, cfg_wr_data);
            if (s_valid && s_ready) tracker.predict_tick(s_adc_code);
            if (m_valid && m_ready)
                tracker.check_result(m_elapsed_ms, m_refresh_pulse, m_sensor_pulse,
                                     m_voltage_update, m_battery_mv);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no item moved for %0d cycles", quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(cfg_idx_t idx, bit [31:0] d);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= d[CFG_DATA_W-1:0];
        @(negedge aclk);
    endtask

    task automatic program_regs(int unsigned refresh, int unsigned sensor_s,
                                int unsigned sample, int unsigned ngain,
                                int unsigned jgain, int unsigned thresh,
                                int unsigned scale, int offset);
        write_reg(CFG_REFRESH_PERIOD, refresh);
        write_reg(CFG_SENSOR_PERIOD_S, sensor_s);
        write_reg(CFG_SAMPLE_PERIOD, sample);
        write_reg(CFG_NORMAL_GAIN, ngain);
        write_reg(CFG_JUMP_GAIN, jgain);
        write_reg(CFG_JUMP_THRESHOLD, thresh);
        write_reg(CFG_CALIB_SCALE, scale);
        write_reg(CFG_CALIB_OFFSET_MV, offset);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    // slowly wandering battery level with noise, jumps and wild codes
    function automatic logic [ADC_BITS-1:0] next_code();
        int v;
        if ($urandom_range(0, 15) == 0) adc_level = $urandom_range(0, CODE_MAX);
        if ($urandom_range(0, 7) == 0) return ADC_BITS'($urandom_range(0, CODE_MAX));
        v = adc_level + int'($urandom_range(0, 16)) - 8;
        if (v < 0) v = 0;
        if (v > CODE_MAX) v = CODE_MAX;
        return v[ADC_BITS-1:0];
    endfunction

    task automatic send_tick(logic [ADC_BITS-1:0] code);
        s_valid <= 1'b1;
        s_adc_code <= code;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        while (tracker.owed_results.size() != 0) @(posedge aclk);
    endtask

    // fixed_code below zero means random codes
    task automatic run_ticks(int count, int fixed_code, int send_idle, int stall,
                             bit mid_pause, bit long_hold);
        stall_pct = stall;
        if (long_hold) hold_requests++;
        for (int i = 0; i < count; i++) begin
            if (mid_pause && i == count / 2) begin
                s_valid <= 1'b0;
                wait_drained();
                @(negedge aclk);
            end
            while ($urandom_range(0, 99) < send_idle) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
            send_tick(fixed_code < 0 ? next_code() : fixed_code[ADC_BITS-1:0]);
        end
        s_valid <= 1'b0;
        wait_drained();
        @(negedge aclk);
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // zero refresh and sensor periods; average step equal to the threshold keeps the
        // normal gain, then a big jump with a gain above one, and a high voltage clamp
        program_regs(0, 0, 1, 0, 511, 100 << FRAC_BITS, (1 << SCALE_W) - 1, 2047);
        run_ticks(5, 0, 0, 0, 0, 0);
        run_ticks(5, 100, 0, 0, 0, 0);
        run_ticks(5, CODE_MAX, 0, 0, 0, 0);

        // largest periods, then lowered below the running counters
        program_regs((1 << REFRESH_W) - 1, (1 << SENSOR_S_W) - 1, (1 << SAMPLE_W) - 1,
                     GAIN_ONE, 0, (1 << THRESH_W) - 1, 0, -2048);
        run_ticks(3, 'hAAA, 0, 0, 0, 0);
        program_regs(2, 0, 0, GAIN_ONE, 0, 0, 0, -2048);
        run_ticks(5, 'h555, 0, 0, 0, 0);

        for (int p = 0; p < 5; p++) begin
            program_regs($urandom_range(0, 12), $urandom_range(0, 1), $urandom_range(0, 3),
                         $urandom_range(0, 300), $urandom_range(0, 511),
                         ($urandom_range(0, 1500) << FRAC_BITS) | $urandom_range(0, 255),
                         $urandom_range(0, (1 << SCALE_W) - 1),
                         int'($urandom_range(0, 4095)) - 2048);
            case (p)
                1: run_ticks(125, -1, 54, 0, 1, 0);
                2: run_ticks(125, -1, 0, 54, 0, 1);
                3: run_ticks(125, -1, 9, 9, 0, 0);
                default: run_ticks(125, -1, 0, 0, 0, 0);
            endcase
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (tracker.owed_results.size() != 0)
            tracker.report("items never returned", tracker.owed_results.size(), 0);
        $display("covered %0d ticks under %0d register settings, %0d voltage updates",
                 tracker.ticks, settings_used, tracker.updates);
        $display("with %0d fast-gain jumps, %0d refresh and %0d sensor pulses",
                 tracker.jumps, tracker.refreshes, tracker.sensors);
        if (tracker.mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/tsbf_pkg.sv
rtl/tsbf_ctrl.sv
rtl/tsbf_dp.sv
rtl/tick_scheduler_battery_filter.sv
rtl/tsbf_chk.sv
verif/tb.sv
